@@ hw/rtl/rs3_pkg.sv @@
// ---------------------------------------------------------------------------
// rs3_pkg
// Shared sizes, register indexes and types of the RGB 3x3 sharpening unit.
// ---------------------------------------------------------------------------
package rs3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    localparam logic [COL_W-1:0] LAST_COL_RST =
        COL_W'((FRAME_WIDTH_RST > MAX_WIDTH ? MAX_WIDTH : FRAME_WIDTH_RST) - 1);
    localparam logic [ROW_W-1:0] LAST_ROW_RST =
        ROW_W'((FRAME_HEIGHT_RST > MAX_HEIGHT ? MAX_HEIGHT : FRAME_HEIGHT_RST) - 1);

    // Pixel: red [7:0], green [15:8], blue [23:16]
    typedef logic [PIX_W-1:0] t_pix;

    // One window column: [0] two rows up, [1] row above, [2] current row
    typedef logic [2:0][PIX_W-1:0] t_column;

    typedef struct packed {
        logic any;      // at least one centre released
        logic top;      // upper centre sits on row 0
        logic bot;      // current row is the last one
        logic ledge;    // left centre sits on column 0
        logic right;    // current column is the last one
    } t_item_flags;

endpackage

@@ hw/rtl/rs3_ram.sv @@
// ---------------------------------------------------------------------------
// rs3_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module rs3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/rs3_ctrl.sv @@
// ---------------------------------------------------------------------------
// rs3_ctrl
// Frame size registers, raster position counters and border flags.
// ---------------------------------------------------------------------------
module rs3_ctrl import rs3_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_advance,
    output logic [COL_W-1:0]      o_col,
    output t_item_flags           o_flags
);

    logic [COL_W-1:0] r_last_col, n_last_col, cfg_last_col;
    logic [ROW_W-1:0] r_last_row, n_last_row, cfg_last_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    // Size saturated to 2..MAX, kept as last index
    always_comb begin
        if (i_cfg_data < CFG_DATA_W'(2)) begin
            cfg_last_col = COL_W'(1);
        end else if (int'(i_cfg_data) > MAX_WIDTH) begin
            cfg_last_col = COL_W'(MAX_WIDTH - 1);
        end else begin
            cfg_last_col = COL_W'(i_cfg_data - CFG_DATA_W'(1));
        end
        if (i_cfg_data < CFG_DATA_W'(2)) begin
            cfg_last_row = ROW_W'(1);
        end else if (int'(i_cfg_data) > MAX_HEIGHT) begin
            cfg_last_row = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            cfg_last_row = ROW_W'(i_cfg_data - CFG_DATA_W'(1));
        end
    end

    always_comb begin
        n_last_col = r_last_col;
        n_last_row = r_last_row;
        n_col      = r_col;
        n_row      = r_row;
        if (i_cfg_wr && (i_cfg_index == CFG_FRAME_WIDTH)) begin
            n_last_col = cfg_last_col;
            n_col      = '0;
            n_row      = '0;
        end else if (i_cfg_wr && (i_cfg_index == CFG_FRAME_HEIGHT)) begin
            n_last_row = cfg_last_row;
            n_col      = '0;
            n_row      = '0;
        end else if (i_advance) begin
            if (r_col == r_last_col) begin
                n_col = '0;
                n_row = (r_row == r_last_row) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= LAST_COL_RST;
            r_last_row <= LAST_ROW_RST;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            r_last_col <= n_last_col;
            r_last_row <= n_last_row;
            r_col      <= n_col;
            r_row      <= n_row;
        end
    end

    assign o_col         = r_col;
    assign o_flags.any   = (r_row != '0) && (r_col != '0);
    assign o_flags.top   = (r_row == ROW_W'(1));
    assign o_flags.bot   = (r_row == r_last_row);
    assign o_flags.ledge = (r_col == COL_W'(1));
    assign o_flags.right = (r_col == r_last_col);

endmodule

@@ hw/rtl/rs3_emit.sv @@
// ---------------------------------------------------------------------------
// rs3_emit
// 3x3 window, centre sequencer, kernel arithmetic and output register.
// ---------------------------------------------------------------------------
module rs3_emit import rs3_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_column     i_column,
    input  t_item_flags i_flags,
    output logic        o_free,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        o_m_tlast,
    output logic        o_m_tuser    // frame end
);

    t_column     r_win [3];
    t_item_flags r_flags;
    logic        r_valid;
    logic        r_rsel;
    logic        r_csel;
    logic        r_out_valid;
    t_pix        r_out_data;
    logic        r_out_last;
    logic        r_out_frame;

    logic        emit, last, has_next_col, has_next_row;
    t_column     col_l, col_m, col_r, g_l, g_m, g_r;
    t_pix        n_out_data;

    function automatic t_column pick_rows(input t_column col, input logic rsel,
                                          input logic top);
        t_column g;
        if (!rsel) begin
            g[0] = top ? col[1] : col[0];
            g[1] = col[1];
            g[2] = col[2];
        end else begin
            g[0] = col[1];
            g[1] = col[2];
            g[2] = col[2];
        end
        return g;
    endfunction

    function automatic logic [CH_W-1:0] sharpen(
        input logic [CH_W-1:0] m,
        input logic [CH_W-1:0] e0, input logic [CH_W-1:0] e1,
        input logic [CH_W-1:0] e2, input logic [CH_W-1:0] e3,
        input logic [CH_W-1:0] c0, input logic [CH_W-1:0] c1,
        input logic [CH_W-1:0] c2, input logic [CH_W-1:0] c3);
        logic        [CH_W+1:0] edges;
        logic        [CH_W+1:0] corners;
        logic        [CH_W+3:0] neg;
        logic signed [CH_W+4:0] s;
        logic        [CH_W-1:0] q;
        edges   = {2'b00, e0} + {2'b00, e1} + {2'b00, e2} + {2'b00, e3};
        corners = {2'b00, c0} + {2'b00, c1} + {2'b00, c2} + {2'b00, c3};
        neg     = {2'b00, corners} + {1'b0, edges, 1'b0};
        s       = $signed({1'b0, m, 4'b0000}) - $signed({1'b0, neg});
        if (s[CH_W+4]) begin
            q = '0;
        end else if (|s[CH_W+3:CH_W+2]) begin
            q = '1;
        end else begin
            q = s[CH_W+1:2];
        end
        return q;
    endfunction

    assign emit         = r_valid && (!r_out_valid || i_m_tready);
    assign has_next_col = !r_csel && r_flags.right;
    assign has_next_row = !r_rsel && r_flags.bot;
    assign last         = !has_next_col && !has_next_row;
    assign o_free       = !r_valid || (emit && last);

    always_comb begin
        if (!r_csel) begin
            col_l = r_flags.ledge ? r_win[1] : r_win[0];
            col_m = r_win[1];
            col_r = r_win[2];
        end else begin
            col_l = r_win[1];
            col_m = r_win[2];
            col_r = r_win[2];
        end
        g_l = pick_rows(col_l, r_rsel, r_flags.top);
        g_m = pick_rows(col_m, r_rsel, r_flags.top);
        g_r = pick_rows(col_r, r_rsel, r_flags.top);
        for (int k = 0; k < 3; k++) begin
            n_out_data[k*CH_W +: CH_W] = sharpen(
                g_m[1][k*CH_W +: CH_W],
                g_m[0][k*CH_W +: CH_W], g_m[2][k*CH_W +: CH_W],
                g_l[1][k*CH_W +: CH_W], g_r[1][k*CH_W +: CH_W],
                g_l[0][k*CH_W +: CH_W], g_l[2][k*CH_W +: CH_W],
                g_r[0][k*CH_W +: CH_W], g_r[2][k*CH_W +: CH_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_rsel      <= 1'b0;
            r_csel      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_valid <= i_flags.any;
                r_rsel  <= 1'b0;
                r_csel  <= 1'b0;
            end else if (emit) begin
                if (last) begin
                    r_valid <= 1'b0;
                end else if (has_next_col) begin
                    r_csel <= 1'b1;
                end else begin
                    r_rsel <= 1'b1;
                    r_csel <= 1'b0;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= i_column;
            r_flags  <= i_flags;
        end
        if (emit) begin
            r_out_data  <= n_out_data;
            r_out_last  <= last;
            r_out_frame <= r_rsel && r_csel;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_frame;

endmodule

@@ hw/rtl/rgb_sharpen_3x3_unit.sv @@
// ---------------------------------------------------------------------------
// rgb_sharpen_3x3_unit
// Streaming 3x3 sharpening filter for RGB frames, replicated borders.
// ---------------------------------------------------------------------------
// Takes one pixel per clock in raster order unless the input is held, and
// releases each centre once its lower-right neighbour has arrived; the result
// passes the input, window and output registers. The output gives one word
// per clock while not stalled, so a pixel that releases several results
// holds the input until all are out: 2 at the last column, 2 per pixel on the
// last row, 4 on the final pixel; elsewhere 1 (none on first row and column).
// Two earlier rows sit in one 48-bit wide line RAM of MAX_WIDTH entries,
// read once and written once per pixel; it needs no clearing after reset.
// A write to either size register restarts the frame at the top-left pixel.
module rgb_sharpen_3x3_unit import rs3_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [23:0]           i_s_tdata,   // in_red, in_green, in_blue
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [23:0]           o_m_tdata,   // out_red, out_green, out_blue
    output logic                  o_m_tlast,   // run_last
    output logic                  o_m_tuser,   // frame_last
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic               s_accept, s1_go, s2_free;
    logic [COL_W-1:0]   pos_col;
    t_item_flags        pos_flags;
    logic [2*PIX_W-1:0] rd_word;
    t_column            s1_column;

    logic               r_s1_valid;
    t_pix               r_s1_pix;
    logic [COL_W-1:0]   r_s1_col;
    t_item_flags        r_s1_flags;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_s1_valid || s2_free;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign s1_go       = r_s1_valid && s2_free;

    rs3_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (s_accept),
        .o_col       (pos_col),
        .o_flags     (pos_flags)
    );

    // Word: row above in the upper half, two rows up in the lower half
    rs3_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({r_s1_pix, rd_word[2*PIX_W-1:PIX_W]}),
        .i_rd_en   (s_accept),
        .i_rd_addr (pos_col),
        .o_rd_data (rd_word)
    );

    assign s1_column[0] = rd_word[PIX_W-1:0];
    assign s1_column[1] = rd_word[2*PIX_W-1:PIX_W];
    assign s1_column[2] = r_s1_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_pix   <= i_s_tdata;
            r_s1_col   <= pos_col;
            r_s1_flags <= pos_flags;
        end
    end

    rs3_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (s1_go),
        .i_column   (s1_column),
        .i_flags    (r_s1_flags),
        .o_free     (s2_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

@@ test/rgb_sharpen_3x3_check.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rgb_sharpen_3x3_check
// Predicts and checks every output word of the RGB 3x3 sharpening unit.
// ---------------------------------------------------------------------------
// Watches the pixel, result and size-register channels. Each accepted pixel
// is written to a private three-row line store. Every centre that the pixel
// releases is sharpened here and queued in raster order. Each accepted
// output word is compared field by field with the oldest queued word.
// Hands the mismatch count, the number of words still owed and the number
// of words compared to the testbench top.
// ---------------------------------------------------------------------------
module rgb_sharpen_3x3_check import rs3_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [PIX_W-1:0]      i_s_tdata,   // in_red, in_green, in_blue
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [PIX_W-1:0]      i_m_tdata,   // out_red, out_green, out_blue
    input  logic                  i_m_tlast,   // run_last
    input  logic                  i_m_tuser,   // frame_last
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_words_checked
);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            run_last;
        logic            frame_last;
    } t_sharp_word;

    t_pix                  line_px [3][MAX_WIDTH];
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    int                    row_at;
    int                    col_at;
    t_sharp_word           sharpened_q [$];
    int                    fails = 0;
    int                    words = 0;

    function automatic int clip(input int v, input int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int size_in_use(input logic [CFG_DATA_W-1:0] v, input int ceiling);
        if (int'(v) < 2) return 2;
        if (int'(v) > ceiling) return ceiling;
        return int'(v);
    endfunction

    // negative sums go to 0, the rest are quartered (floor) and clamped
    function automatic logic [CH_W-1:0] squash(input int s);
        if (s < 0) return '0;
        if ((s >>> 2) > 255) return '1;
        return CH_W'(s >>> 2);
    endfunction

    function automatic t_sharp_word sharpen(input int ci, input int cj,
                                            input int last_r, input int last_c);
        int          acc_r;
        int          acc_g;
        int          acc_b;
        int          wt;
        t_pix        p;
        t_sharp_word res;
        acc_r = 0;
        acc_g = 0;
        acc_b = 0;
        for (int k = 0; k < 3; k++) begin
            for (int l = 0; l < 3; l++) begin
                p  = line_px[clip(ci + k - 1, last_r) % 3][clip(cj + l - 1, last_c)];
                wt = (k == 1 && l == 1) ? 16 : ((k == 1 || l == 1) ? -2 : -1);
                acc_r += wt * int'(p[7:0]);
                acc_g += wt * int'(p[15:8]);
                acc_b += wt * int'(p[23:16]);
            end
        end
        res.red        = squash(acc_r);
        res.green      = squash(acc_g);
        res.blue       = squash(acc_b);
        res.run_last   = 1'b0;
        res.frame_last = (ci == last_r && cj == last_c);
        return res;
    endfunction

    task automatic sharpen_pixel(input t_pix px);
        int          w;
        int          h;
        int          r;
        int          c;
        int          rsel [2];
        int          csel [2];
        int          nr;
        int          nc;
        int          idx;
        t_sharp_word res;
        w  = size_in_use(width_reg, MAX_WIDTH);
        h  = size_in_use(height_reg, MAX_HEIGHT);
        r  = (row_at >= h) ? 0 : row_at;
        c  = (col_at >= w) ? 0 : col_at;
        nr = 0;
        nc = 0;
        line_px[r % 3][c] = px;
        if (r >= 1) begin
            rsel[nr] = r - 1;
            nr++;
        end
        if (r == h - 1) begin
            rsel[nr] = r;
            nr++;
        end
        if (c >= 1) begin
            csel[nc] = c - 1;
            nc++;
        end
        if (c == w - 1) begin
            csel[nc] = c;
            nc++;
        end
        idx = 0;
        for (int a = 0; a < nr; a++) begin
            for (int b = 0; b < nc; b++) begin
                res          = sharpen(rsel[a], csel[b], h - 1, w - 1);
                res.run_last = (idx == nr * nc - 1);
                sharpened_q  = {sharpened_q, res};
                idx++;
            end
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        row_at = r;
        col_at = c;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fails < 40)
            $display("[%0t] mismatch on %s, word %0d: got %0d, want %0d",
                     $time, what, words, got, want);
        fails++;
    endtask

    task automatic check_word();
        t_sharp_word want;
        words++;
        if (sharpened_q.size() == 0) begin
            report_mismatch("word with nothing owed", int'(i_m_tdata), 0);
        end else begin
            want = sharpened_q.pop_front();
            if (i_m_tdata[7:0] !== want.red)
                report_mismatch("red", int'(i_m_tdata[7:0]), int'(want.red));
            if (i_m_tdata[15:8] !== want.green)
                report_mismatch("green", int'(i_m_tdata[15:8]), int'(want.green));
            if (i_m_tdata[23:16] !== want.blue)
                report_mismatch("blue", int'(i_m_tdata[23:16]), int'(want.blue));
            if (i_m_tlast !== want.run_last)
                report_mismatch("tlast", int'(i_m_tlast), int'(want.run_last));
            if (i_m_tuser !== want.frame_last)
                report_mismatch("tuser", int'(i_m_tuser), int'(want.frame_last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = CFG_DATA_W'(FRAME_WIDTH_RST);
            height_reg = CFG_DATA_W'(FRAME_HEIGHT_RST);
            row_at     = 0;
            col_at     = 0;
            sharpened_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                // either size register restarts the frame
                if (i_cfg_index == CFG_FRAME_WIDTH) begin
                    width_reg = i_cfg_data;
                    row_at    = 0;
                    col_at    = 0;
                end else if (i_cfg_index == CFG_FRAME_HEIGHT) begin
                    height_reg = i_cfg_data;
                    row_at     = 0;
                    col_at     = 0;
                end
            end
            if (i_m_tvalid && i_m_tready) check_word();
            if (i_s_tvalid && i_s_tready) sharpen_pixel(i_s_tdata);
        end
        o_pending       <= sharpened_q.size();
        o_fail_count    <= fails;
        o_words_checked <= words;
    end

endmodule

@@ test/rgb_sharpen_3x3_unit_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rgb_sharpen_3x3_unit_test
// Stimulus and verdict for the RGB 3x3 sharpening unit.
// ---------------------------------------------------------------------------
// Streams raster-order pixels through small frame sizes: sizes below range
// (giving 2x2), hand-made 2x2 and 3x3 frames that hit the clamps and the
// four-word pixel, a 6x4 frame under a long output hold so the unit backs
// up, a 9x6 frame with no idling, then random small frames, some cut short
// and restarted by a size write. Both sides otherwise idle at random.
// Checking lives in rgb_sharpen_3x3_check.
// ---------------------------------------------------------------------------
module rgb_sharpen_3x3_unit_test;
    import rs3_pkg::*;

    localparam int                   LIMIT_CYCLES  = 500000;
    localparam int                   DRAIN_CYCLES  = 8;
    localparam int                   HOLD_CYCLES   = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(9);

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic [PIX_W-1:0]      i_s_tdata   = '0;
    logic                  i_m_tready  = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [PIX_W-1:0]      o_m_tdata;
    logic                  o_m_tlast;
    logic                  o_m_tuser;
    logic                  o_cfg_ready;

    int                    fail_count;
    int                    pending;
    int                    words_checked;
    int                    cycles      = 0;
    int                    pixels_sent = 0;
    int                    reg_writes  = 0;
    logic                  calm        = 1'b0;
    logic                  hold_req    = 1'b0;
    logic [CFG_DATA_W-1:0] cur_w       = CFG_DATA_W'(FRAME_WIDTH_RST);
    logic [CFG_DATA_W-1:0] cur_h       = CFG_DATA_W'(FRAME_HEIGHT_RST);

    rgb_sharpen_3x3_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    rgb_sharpen_3x3_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .i_s_tready      (o_s_tready),
        .i_s_tdata       (i_s_tdata),
        .i_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .i_m_tdata       (o_m_tdata),
        .i_m_tlast       (o_m_tlast),
        .i_m_tuser       (o_m_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_pix rgb(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                 input logic [CH_W-1:0] b);
        return {b, g, r};
    endfunction

    // channels lean towards 0 and 255 to reach the clamps often
    function automatic t_pix rand_pixel();
        t_pix p;
        for (int ch = 0; ch < 3; ch++) begin
            case ($urandom_range(0, 3))
                0:       p[ch*CH_W +: CH_W] = '0;
                1:       p[ch*CH_W +: CH_W] = '1;
                default: p[ch*CH_W +: CH_W] = CH_W'($urandom);
            endcase
        end
        return p;
    endfunction

    function automatic int size_in_use(input logic [CFG_DATA_W-1:0] v, input int ceiling);
        if (int'(v) < 2) return 2;
        if (int'(v) > ceiling) return ceiling;
        return int'(v);
    endfunction

    task automatic send_pixel(input t_pix px);
        while (!calm && $urandom_range(0, 99) < 8) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= px;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic send_run(input int count);
        repeat (count) send_pixel(rand_pixel());
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_FRAME_WIDTH) cur_w = data;
        if (idx == CFG_FRAME_HEIGHT) cur_h = data;
        reg_writes++;
    endtask

    task automatic set_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
    endtask

    // wait for every owed word, then let the pipeline empty
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // output side: random stalls, one long hold on request
    initial begin
        int  hold_left;
        logic hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_tready <= calm || ($urandom_range(0, 99) >= 8);
            end
        end
    end

    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("rgb_sharpen_3x3_unit_test NOT OK");
        $finish;
    end

    initial begin
        int                    rand_pixels;
        int                    run_len;
        int                    w_eff;
        int                    h_eff;
        logic [CFG_DATA_W-1:0] nw;
        logic [CFG_DATA_W-1:0] nh;
        rand_pixels = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // widths/heights below range give 2x2; last pixel releases four words
        set_size(CFG_DATA_W'(0), CFG_DATA_W'(1));
        send_pixel(rgb(255, 255, 255));
        send_pixel(rgb(0, 0, 0));
        send_pixel(rgb(0, 0, 0));
        send_pixel(rgb(255, 255, 255));
        send_pixel(rgb(0, 255, 0));
        send_pixel(rgb(255, 0, 255));
        send_pixel(rgb(128, 1, 254));
        send_pixel(rgb(3, 200, 77));
        settle();

        // 3x3: bright centre on black, then black centre on white
        set_size(CFG_DATA_W'(3), CFG_DATA_W'(3));
        for (int k = 0; k < 9; k++)
            send_pixel(k == 4 ? rgb(255, 255, 255) : rgb(0, 0, 0));
        for (int k = 0; k < 4; k++)
            send_pixel(rgb(255, 255, 255));
        settle();
        // unknown index must not restart the frame
        write_reg(CFG_SPARE_IDX, '1);
        for (int k = 4; k < 9; k++)
            send_pixel(k == 4 ? rgb(0, 0, 0) : rgb(255, 255, 255));
        settle();

        // 6x4 frame under the long output hold
        set_size(CFG_DATA_W'(6), CFG_DATA_W'(4));
        hold_req = 1'b1;
        send_run(24);
        settle();

        // 9x6 frame, no idling on either side
        calm = 1'b1;
        set_size(CFG_DATA_W'(9), CFG_DATA_W'(6));
        send_run(54);
        settle();
        calm = 1'b0;

        // random small frames, some cut short
        while (rand_pixels < 100) begin
            nw = ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom_range(0, 1))
                                             : CFG_DATA_W'($urandom_range(2, 9));
            nh = ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom_range(0, 1))
                                             : CFG_DATA_W'($urandom_range(2, 6));
            case ($urandom_range(0, 2))
                0:       write_reg(CFG_FRAME_WIDTH, nw);
                1:       write_reg(CFG_FRAME_HEIGHT, nh);
                default: set_size(nw, nh);
            endcase
            if (rand_pixels == 0 && (cur_w != nw || cur_h != nh)) set_size(nw, nh);
            w_eff = size_in_use(cur_w, MAX_WIDTH);
            h_eff = size_in_use(cur_h, MAX_HEIGHT);
            repeat ($urandom_range(1, 2)) begin
                run_len = w_eff * h_eff;
                if ($urandom_range(0, 4) == 0) run_len = $urandom_range(1, run_len - 1);
                send_run(run_len);
                rand_pixels += run_len;
            end
            settle();
        end

        $display("Sent %0d pixels with %0d register writes; %0d sharpened words compared.",
                 pixels_sent, reg_writes, words_checked);
        $display("Frames from 2x2 to 9x6, under-range sizes, a spare index, %0d-cycle hold.",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("rgb_sharpen_3x3_unit_test OK");
        else
            $display("rgb_sharpen_3x3_unit_test NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/rs3_pkg.sv
hw/rtl/rs3_ram.sv
hw/rtl/rs3_ctrl.sv
hw/rtl/rs3_emit.sv
hw/rtl/rgb_sharpen_3x3_unit.sv
test/rgb_sharpen_3x3_check.sv
test/rgb_sharpen_3x3_unit_test.sv
